// ===== hdl/quadrature_pid_position_axis_defines.svh =====
// Assertion macros for the top-level file, which carries the concurrent checks.
`ifndef QUADRATURE_PID_POSITION_AXIS_DEFINES_SVH
`define QUADRATURE_PID_POSITION_AXIS_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define QPP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("quadrature axis check failed");

// Next-cycle implication, disabled while reset is high.
`define QPP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("quadrature axis check failed");

`endif

// ===== hdl/qpp_pkg.sv =====
package qpp_pkg;

   localparam int POS_W   = 24;
   localparam int ERR_W   = 25;
   localparam int INTEG_W = 32;
   localparam int DIFF_W  = 26;
   localparam int GAIN_W  = 24;
   localparam int DUTY_W  = 8;
   localparam int SUM_W   = 58;

   localparam int REQ_DATA_W = 8;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 64;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam int ERR_LIMIT = 16777215;

   typedef enum logic [1:0] {
      ACT_EDGE = 2'd0,
      ACT_TICK = 2'd1,
      ACT_MOVE = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REFERENCE = 3'd0,
      CSR_KP        = 3'd1,
      CSR_KI        = 3'd2,
      CSR_KD        = 3'd3,
      CSR_DUTY_MAX  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [POS_W-1:0] reference_count;
      logic [GAIN_W-1:0]       kp_gain;
      logic [GAIN_W-1:0]       ki_gain;
      logic [GAIN_W-1:0]       kd_gain;
      logic [DUTY_W-1:0]       duty_max;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      reference_count: 24'sd0,
      kp_gain:         24'd125577,
      ki_gain:         24'd628,
      kd_gain:         24'd125577,
      duty_max:        8'd100
   };

   // Item handed from the PID pipeline to the drive stage.
   typedef struct packed {
      action_type              action;
      logic [POS_W-1:0]        position;
      logic signed [ERR_W-1:0] err;
      logic signed [SUM_W-1:0] sum;
   } drive_item_type;

endpackage

// ===== hdl/qpp_counter.sv =====
module qpp_counter
   import qpp_pkg::*;
#(
   parameter int COUNT_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  action_type            in_action,
   input  logic                  in_edge_on_b,
   input  logic                  in_level_a,
   input  logic                  in_level_b,
   output logic                  out_valid,
   input  logic                  out_ready,
   output action_type            out_action,
   output logic [COUNT_BITS-1:0] out_count
);

   logic                  valid_ff;
   action_type            action_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [COUNT_BITS-1:0] count_in;
   logic                  up;
   logic                  load;

   // The stage register doubles as the count itself: it always holds the
   // count after the item it carries.
   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign up       = in_edge_on_b ? (in_level_a == in_level_b) : (in_level_a != in_level_b);
   assign count_in = up ? count_ff + 1'b1 : count_ff - 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (load && (in_action == ACT_EDGE)) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         action_ff <= in_action;
      end
   end

   assign out_valid  = valid_ff;
   assign out_action = action_ff;
   assign out_count  = count_ff;

endmodule

// ===== hdl/qpp_pid.sv =====
module qpp_pid
   import qpp_pkg::*;
#(
   parameter int COUNT_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  action_type            in_action,
   input  logic [COUNT_BITS-1:0] in_count,
   output logic                  out_valid,
   input  logic                  out_ready,
   output drive_item_type        out_item
);

   localparam int EW    = ((COUNT_BITS > POS_W) ? COUNT_BITS : POS_W) + 1;
   localparam int ACC_W = INTEG_W + 1;
   localparam int P_W   = GAIN_W + 1 + ERR_W;
   localparam int I_W   = GAIN_W + 1 + INTEG_W;
   localparam int D_W   = GAIN_W + 1 + DIFF_W;
   localparam logic signed [EW-1:0] LIM_POS = EW'(ERR_LIMIT);
   localparam logic signed [EW-1:0] LIM_NEG = -LIM_POS;

   // Stage A: position error.
   logic                    a_valid_ff;
   action_type              a_action_ff;
   logic [POS_W-1:0]        a_pos_ff;
   logic signed [ERR_W-1:0] a_err_ff;
   logic signed [EW-1:0]    raw_err;
   logic signed [ERR_W-1:0] err_in;

   // Stage B: integral and derivative state.
   logic                      b_valid_ff;
   action_type                b_action_ff;
   logic [POS_W-1:0]          b_pos_ff;
   logic signed [ERR_W-1:0]   b_err_ff;
   logic signed [INTEG_W-1:0] b_integ_ff;
   logic signed [DIFF_W-1:0]  b_diff_ff;
   logic signed [INTEG_W-1:0] integ_ff;
   logic signed [ERR_W-1:0]   prev_ff;
   logic signed [ACC_W-1:0]   acc;
   logic signed [INTEG_W-1:0] integ_in;
   logic signed [DIFF_W-1:0]  diff_in;

   // Stage C: gain products.
   logic                    c_valid_ff;
   action_type              c_action_ff;
   logic [POS_W-1:0]        c_pos_ff;
   logic signed [ERR_W-1:0] c_err_ff;
   logic signed [P_W-1:0]   c_p_ff;
   logic signed [I_W-1:0]   c_i_ff;
   logic signed [D_W-1:0]   c_d_ff;
   logic signed [GAIN_W:0]  kp_s;
   logic signed [GAIN_W:0]  ki_s;
   logic signed [GAIN_W:0]  kd_s;

   // Stage D: controller sum.
   logic                    d_valid_ff;
   drive_item_type          d_item_ff;
   logic signed [SUM_W-1:0] sum_in;

   logic rdy_a;
   logic rdy_b;
   logic rdy_c;
   logic rdy_d;

   assign rdy_d    = !d_valid_ff || out_ready;
   assign rdy_c    = !c_valid_ff || rdy_d;
   assign rdy_b    = !b_valid_ff || rdy_c;
   assign rdy_a    = !a_valid_ff || rdy_b;
   assign in_ready = rdy_a;

   always_comb begin
      raw_err = EW'(cfg.reference_count) - EW'($signed(in_count));
      if (raw_err > LIM_POS) begin
         err_in = ERR_W'(LIM_POS);
      end else if (raw_err < LIM_NEG) begin
         err_in = ERR_W'(LIM_NEG);
      end else begin
         err_in = ERR_W'(raw_err);
      end
   end

   always_comb begin
      acc = ACC_W'(integ_ff) + ACC_W'(a_err_ff);
      if (acc[ACC_W-1] != acc[ACC_W-2]) begin
         integ_in = acc[ACC_W-1] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
      end else begin
         integ_in = acc[INTEG_W-1:0];
      end
      diff_in = DIFF_W'(a_err_ff) - DIFF_W'(prev_ff);
   end

   assign kp_s   = $signed({1'b0, cfg.kp_gain});
   assign ki_s   = $signed({1'b0, cfg.ki_gain});
   assign kd_s   = $signed({1'b0, cfg.kd_gain});
   assign sum_in = SUM_W'(c_p_ff) + SUM_W'(c_i_ff) + SUM_W'(c_d_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         integ_ff   <= '0;
         prev_ff    <= '0;
      end else begin
         if (rdy_a) begin
            a_valid_ff <= in_valid;
         end
         if (rdy_b) begin
            b_valid_ff <= a_valid_ff;
         end
         if (rdy_c) begin
            c_valid_ff <= b_valid_ff;
         end
         if (rdy_d) begin
            d_valid_ff <= c_valid_ff;
         end
         if (rdy_b && a_valid_ff) begin
            unique case (a_action_ff)
               ACT_TICK: begin
                  integ_ff <= integ_in;
                  prev_ff  <= a_err_ff;
               end
               ACT_MOVE: begin
                  integ_ff <= '0;
                  prev_ff  <= a_err_ff;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a && in_valid) begin
         a_action_ff <= in_action;
         a_pos_ff    <= POS_W'(in_count);
         a_err_ff    <= err_in;
      end
      if (rdy_b && a_valid_ff) begin
         b_action_ff <= a_action_ff;
         b_pos_ff    <= a_pos_ff;
         b_err_ff    <= a_err_ff;
         b_integ_ff  <= integ_in;
         b_diff_ff   <= diff_in;
      end
      if (rdy_c && b_valid_ff) begin
         c_action_ff <= b_action_ff;
         c_pos_ff    <= b_pos_ff;
         c_err_ff    <= b_err_ff;
         c_p_ff      <= P_W'(kp_s) * P_W'(b_err_ff);
         c_i_ff      <= I_W'(ki_s) * I_W'(b_integ_ff);
         c_d_ff      <= D_W'(kd_s) * D_W'(b_diff_ff);
      end
      if (rdy_d && c_valid_ff) begin
         d_item_ff.action   <= c_action_ff;
         d_item_ff.position <= c_pos_ff;
         d_item_ff.err      <= c_err_ff;
         d_item_ff.sum      <= sum_in;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_item  = d_item_ff;

endmodule

// ===== hdl/qpp_drive.sv =====
module qpp_drive
   import qpp_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [DUTY_W-1:0]       duty_max,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  drive_item_type          in_item,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [POS_W-1:0]        out_position,
   output logic signed [ERR_W-1:0] out_error,
   output logic [DUTY_W-1:0]       out_duty,
   output logic                    out_forward
);

   logic                    valid_ff;
   logic [POS_W-1:0]        pos_ff;
   logic signed [ERR_W-1:0] err_ff;
   logic [DUTY_W-1:0]       duty_ff;
   logic                    fwd_ff;
   logic [SUM_W-1:0]        mag;
   logic [SUM_W-1:0]        shifted;
   logic [DUTY_W-1:0]       duty_in;
   logic                    load;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   // Magnitude, drop the fraction bits, then clamp to the PWM range.
   always_comb begin
      mag     = in_item.sum[SUM_W-1] ? SUM_W'(-in_item.sum) : SUM_W'(in_item.sum);
      shifted = mag >> GAIN_FRAC_BITS;
      duty_in = (shifted > SUM_W'(duty_max)) ? duty_max : shifted[DUTY_W-1:0];
   end

   // The drive registers are the drive state: they only change on a tick, so
   // every other item reports the last tick's result.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         duty_ff  <= '0;
         fwd_ff   <= 1'b1;
      end else begin
         if (in_ready) begin
            valid_ff <= in_valid;
         end
         if (load && (in_item.action == ACT_TICK)) begin
            duty_ff <= duty_in;
            fwd_ff  <= !in_item.err[ERR_W-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pos_ff <= in_item.position;
         err_ff <= in_item.err;
      end
   end

   assign out_valid    = valid_ff;
   assign out_position = pos_ff;
   assign out_error    = err_ff;
   assign out_duty     = duty_ff;
   assign out_forward  = fwd_ff;

endmodule

// ===== hdl/quadrature_pid_position_axis.sv =====
// Channel  Dir  Handshake              Payload
// req_     in   req_tvalid/req_tready  tuser: action; tdata: edge_on_b, level_a, level_b
// rsp_     out  rsp_tvalid/rsp_tready  tdata: position, position_error, duty, forward
// csr_     in   csr_valid/csr_ready    csr_index, csr_data (register write)
//
// One transaction is accepted per clock unless a stall on rsp_ backs up the pipeline;
// every accepted transaction yields one result through the six-register pipeline:
// count, error, integral, gain products, sum, and the clamped drive stage.
// Reset is synchronous and active high; it clears the count, the integral, the
// previous error and the drive (duty 0, forward 1), and restores register defaults.
// A stall on rsp_ only backs up stages that are full, so bubbles still fill.
`include "quadrature_pid_position_axis_defines.svh"

module quadrature_pid_position_axis
   import qpp_pkg::*;
#(
   parameter int COUNT_BITS     = 24,
   parameter int GAIN_FRAC_BITS = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [0] edge_on_b, [1] level_a, [2] level_b, rest zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] action
   input  logic [REQ_USER_W-1:0] req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [23:0] position, [48:24] position_error, [56:49] duty, [57] forward, rest zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int RSP_PAD = RSP_DATA_W - (POS_W + ERR_W + DUTY_W + 1);

   cfg_type                 cfg_ff;
   action_type              req_action;
   logic                    req_accept;

   logic                    cnt_valid;
   logic                    cnt_ready;
   action_type              cnt_action;
   logic [COUNT_BITS-1:0]   count_w;

   logic                    pid_valid;
   logic                    pid_ready;
   drive_item_type          pid_item;

   logic [POS_W-1:0]        rsp_position;
   logic signed [ERR_W-1:0] rsp_error;
   logic [DUTY_W-1:0]       rsp_duty;
   logic                    rsp_forward;

   // Configuration registers. Writes are taken in any cycle; the user writes
   // them only while no transaction is in flight.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_REFERENCE: cfg_ff.reference_count <= $signed(csr_data);
            CSR_KP:        cfg_ff.kp_gain         <= csr_data;
            CSR_KI:        cfg_ff.ki_gain         <= csr_data;
            CSR_KD:        cfg_ff.kd_gain         <= csr_data;
            CSR_DUTY_MAX:  cfg_ff.duty_max        <= csr_data[DUTY_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_action = action_type'(req_tuser);
   assign req_accept = req_tvalid && req_tready;

   // First stage: the quadrature count changes as the transaction is taken.
   qpp_counter #(
      .COUNT_BITS (COUNT_BITS)
   ) u_counter (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_action    (req_action),
      .in_edge_on_b (req_tdata[0]),
      .in_level_a   (req_tdata[1]),
      .in_level_b   (req_tdata[2]),
      .out_valid    (cnt_valid),
      .out_ready    (cnt_ready),
      .out_action   (cnt_action),
      .out_count    (count_w)
   );

   // Error, integral, products and sum; the controller state lives here.
   qpp_pid #(
      .COUNT_BITS (COUNT_BITS)
   ) u_pid (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (cnt_valid),
      .in_ready  (cnt_ready),
      .in_action (cnt_action),
      .in_count  (count_w),
      .out_valid (pid_valid),
      .out_ready (pid_ready),
      .out_item  (pid_item)
   );

   // Clamp and direction, then the result register that faces rsp_.
   qpp_drive #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_drive (
      .clock        (clock),
      .reset        (reset),
      .duty_max     (cfg_ff.duty_max),
      .in_valid     (pid_valid),
      .in_ready     (pid_ready),
      .in_item      (pid_item),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .out_position (rsp_position),
      .out_error    (rsp_error),
      .out_duty     (rsp_duty),
      .out_forward  (rsp_forward)
   );

   assign rsp_tdata = {{RSP_PAD{1'b0}}, rsp_forward, rsp_duty, rsp_error, rsp_position};

   // An encoder edge moves the count by exactly one step, either way.
   `QPP_ASSERT_NXT(a_edge_step, clock, reset, req_accept && (req_action == ACT_EDGE), (count_w == COUNT_BITS'($past(count_w) + 1'b1)) || (count_w == COUNT_BITS'($past(count_w) - 1'b1)))
   // Ticks, move starts and the spare code leave the count alone.
   `QPP_ASSERT_NXT(a_count_hold, clock, reset, req_accept && (req_action != ACT_EDGE), $stable(count_w))
   // Only a tick entering the drive stage may change the reported drive.
   `QPP_ASSERT_NXT(a_drive_hold, clock, reset, pid_valid && pid_ready && (pid_item.action != ACT_TICK), $stable(rsp_duty) && $stable(rsp_forward))

endmodule
